### design/ghbp_pkg.sv
package ghbp_pkg;

  // Table geometry
  localparam int PC_INDEX_BITS = 12;
  localparam int HISTORY_BITS  = 4;
  localparam int TABLE_BITS    = PC_INDEX_BITS + HISTORY_BITS;
  localparam int TABLE_DEPTH   = 1 << TABLE_BITS;
  localparam int ADDRESS_WIDTH = 32;

  // Front-to-back queue
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [TABLE_BITS-1:0]    table_index_t;
  typedef logic [HISTORY_BITS-1:0]  history_t;
  typedef logic [1:0]               counter_t;
  typedef logic [QPTR_W-1:0]        qptr_t;
  typedef logic [QCNT_W-1:0]        qcount_t;

  // Counter states
  localparam counter_t STRONG_NOT_TAKEN = 2'd0;
  localparam counter_t WEAK_NOT_TAKEN   = 2'd1;
  localparam counter_t WEAK_TAKEN       = 2'd2;
  localparam counter_t STRONG_TAKEN     = 2'd3;

  typedef struct packed {
    table_index_t index;
    logic         taken;
  } queue_entry_t;

  // Reasons for the front to hold off new items
  typedef struct packed {
    logic queue_full;
    logic clearing;
  } front_hold_t;

  // Saturating update with the jump from either weak state to the strong one
  function automatic counter_t next_counter(counter_t cnt, logic taken);
    counter_t res;
    if (taken) begin
      res = (cnt == STRONG_NOT_TAKEN) ? WEAK_NOT_TAKEN : STRONG_TAKEN;
    end else begin
      res = (cnt == STRONG_TAKEN) ? WEAK_TAKEN : STRONG_NOT_TAKEN;
    end
    return res;
  endfunction

endpackage

### design/global_history_branch_predictor.sv
// Channel  Direction  Handshake             Payload
// in       to block   in_valid / in_stall   branch_address[31:0], branch_taken
// out      from block out_valid / out_stall predict_taken
//
// One item per cycle sustained while nothing stalls; an accepted item passes
// through queue, table read with update stage, and output register in turn.
// After rst the counter table is swept to strongly taken, one entry a cycle;
// in_stall stays high until every entry has been written.
// out_stall holds the output register; the update stage and the two-entry
// queue keep taking items until they fill, then in_stall rises.
module global_history_branch_predictor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] branch_address,
  input  logic        branch_taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        predict_taken
);
  import ghbp_pkg::*;

  front_hold_t  hold;
  logic         push;
  queue_entry_t push_entry;
  logic         q_full;
  logic         q_valid;
  queue_entry_t q_entry;
  logic         q_pop;
  logic         clearing;

  assign hold.queue_full = q_full;
  assign hold.clearing   = clearing;

  ghbp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .branch_address (branch_address),
    .branch_taken   (branch_taken),
    .hold           (hold),
    .push           (push),
    .push_entry     (push_entry)
  );

  ghbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (q_pop)
  );

  ghbp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .predict_taken (predict_taken)
  );

endmodule

### design/ghbp_front.sv
module ghbp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ghbp_pkg::ADDRESS_WIDTH-1:0] branch_address,
  input  logic                       branch_taken,
  input  ghbp_pkg::front_hold_t      hold,
  output logic                       push,
  output ghbp_pkg::queue_entry_t     push_entry
);
  import ghbp_pkg::*;

  history_t history;
  history_t history_next;

  // Hold off items while the table clears or the queue is full
  assign in_stall = hold.clearing | hold.queue_full;
  assign push     = in_valid & ~in_stall;

  // Form the table index from history (upper) and low PC bits (lower)
  assign push_entry.index = {history, branch_address[PC_INDEX_BITS-1:0]};
  assign push_entry.taken = branch_taken;

  // Shift the outcome in as the newest bit, oldest drops out
  assign history_next = history_t'({history, branch_taken});

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '1;
    end else if (push) begin
      history <= history_next;
    end
  end

endmodule

### design/ghbp_queue.sv
module ghbp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ghbp_pkg::queue_entry_t push_entry,
  output logic                   full,
  output logic                   pop_valid,
  output ghbp_pkg::queue_entry_t pop_entry,
  input  logic                   pop
);
  import ghbp_pkg::*;

  queue_entry_t slots [QUEUE_DEPTH];
  qptr_t        wr_ptr;
  qptr_t        rd_ptr;
  qcount_t      count;

  assign full      = (count == qcount_t'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + qptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + qptr_t'(1);
      end
      if (push && !pop) begin
        count <= count + qcount_t'(1);
      end else if (pop && !push) begin
        count <= count - qcount_t'(1);
      end
    end
  end

endmodule

### design/ghbp_back.sv
module ghbp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  ghbp_pkg::queue_entry_t q_entry,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   predict_taken
);
  import ghbp_pkg::*;

  counter_t     table_mem [TABLE_DEPTH];
  counter_t     rdata;

  logic         clr_active;
  table_index_t clr_addr;

  logic         e_valid;
  table_index_t e_index;
  logic         e_taken;
  logic         fwd_hit;
  counter_t     fwd_data;

  logic         e_fire;
  logic         issue;
  logic         wr_en;
  table_index_t wr_addr;
  counter_t     wr_data;
  counter_t     cnt_cur;
  counter_t     cnt_next;

  assign clearing = clr_active;

  // Update stage moves when the output register is free or draining
  assign e_fire = e_valid & (~out_valid | ~out_stall);
  assign issue  = q_valid & ~clr_active & (~e_valid | e_fire);
  assign q_pop  = issue;

  // Take the counter written in the issue cycle if it hit the same entry
  assign cnt_cur  = fwd_hit ? fwd_data : rdata;
  assign cnt_next = next_counter(cnt_cur, e_taken);

  // Clearing sweep owns the write port until done
  assign wr_en   = clr_active | e_fire;
  assign wr_addr = clr_active ? clr_addr : e_index;
  assign wr_data = clr_active ? STRONG_TAKEN : cnt_next;

  // Counter table: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata <= table_mem[q_entry.index];
    end
  end

  // Sweep every entry to strongly taken after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + table_index_t'(1);
      if (&clr_addr) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Update stage payload and bypass capture
  always_ff @(posedge clk) begin
    if (issue) begin
      e_index  <= q_entry.index;
      e_taken  <= q_entry.taken;
      fwd_hit  <= wr_en & (wr_addr == q_entry.index);
      fwd_data <= wr_data;
    end
  end

  // Update stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (issue) begin
      e_valid <= 1'b1;
    end else if (e_fire) begin
      e_valid <= 1'b0;
    end
  end

  // Output register: load on fire, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      predict_taken <= cnt_cur[1];
    end
  end

endmodule

### design/ghbp_checker.sv
module ghbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] branch_address,
  input logic        branch_taken,
  input logic        out_valid,
  input logic        out_stall,
  input logic        predict_taken
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pending;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  // Track items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 4'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 4'd1;
    end
  end

  // No intake in the cycle after reset: table sweep under way
  a_sweep_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("item accepted during table sweep");

  // No result without an outstanding item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (pending != 4'd0))
    else $error("result delivered with no item outstanding");

  // Queue, update stage and output register bound what is in flight
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'd4)
    else $error("more items in flight than storage holds");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(predict_taken)))
    else $error("stalled result changed");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=>
      (in_valid && $stable(branch_address) && $stable(branch_taken)))
    else $error("stalled input item changed");

endmodule

bind global_history_branch_predictor ghbp_checker u_ghbp_checker (.*);
